// ===== hdl/lattice_voter_model_step_top_macros.svh =====
// assertion macros shared by the lattice voter step rtl
// depends on nothing; users supply clk and rst_n in scope
`ifndef LATTICE_VOTER_MODEL_STEP_TOP_MACROS_SVH
`define LATTICE_VOTER_MODEL_STEP_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define LVM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LVM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/lvm_pkg.sv =====
// shared types, codes and neighbor tables for the lattice voter step block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lvm_pkg;

  localparam int CFG_W        = 7;
  localparam int CFG_MAX      = 127;
  localparam int LAT_W        = 3;
  localparam int COORD_W      = 6;
  localparam int PICK_W       = 4;
  localparam int OPINION_W    = 2;
  localparam int COUNT_W      = 13;
  localparam int NPOS_W       = 2 * CFG_W;
  localparam int NUM_COUNTS   = 3;
  localparam int REG_IDX_W    = 2;

  localparam int DEF_MAX_COLS    = 64;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_NUM_PARTIES = 3;

  localparam logic [CFG_W-1:0]     RST_COLS    = 7'd64;
  localparam logic [CFG_W-1:0]     RST_ROWS    = 7'd64;
  localparam logic [CFG_W-1:0]     MIN_SIZE    = 7'd2;
  localparam logic [OPINION_W-1:0] OPINION_MAX = 2'd2;

  // lattice codes; the two unused codes behave as square8
  typedef enum logic [LAT_W-1:0] {
    LAT_TRI3    = 3'd0,
    LAT_SQUARE4 = 3'd1,
    LAT_HEX6    = 3'd2,
    LAT_SQUARE8 = 3'd3,
    LAT_TRI9    = 3'd4,
    LAT_TRI12   = 3'd5
  } lattice_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_NEIGHBORHOOD = 2'd0,
    REG_GRID_COLUMNS = 2'd1,
    REG_GRID_ROWS    = 2'd2
  } reg_index_t;

  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_STEP = 1'b1
  } kind_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_WB   = 1'b1
  } state_t;

  typedef struct packed {
    logic                   kind;
    logic [COORD_W-1:0]     cell_col;
    logic [COORD_W-1:0]     cell_row;
    logic [PICK_W-1:0]      neighbor_pick;
    logic [OPINION_W-1:0]   load_opinion;
  } in_word_t;

  typedef struct packed {
    logic [OPINION_W-1:0]   prev_opinion;
    logic [OPINION_W-1:0]   post_opinion;
    logic                   changed;
    logic [COORD_W-1:0]     neighbor_col;
    logic [COORD_W-1:0]     neighbor_row;
    logic                   consensus;
    logic                   bad_coord;
  } out_word_t;

  // neighbor lookup result handed from the address unit
  typedef struct packed {
    logic [COORD_W-1:0]     ncol;
    logic [COORD_W-1:0]     nrow;
    logic                   bad;
  } nbr_res_t;

  // count update request to the tally unit
  typedef struct packed {
    logic                   inc_en;
    logic [OPINION_W-1:0]   inc_idx;
    logic                   dec_en;
    logic [OPINION_W-1:0]   dec_idx;
  } tally_op_t;

  typedef struct packed {
    logic signed [2:0]      dc;
    logic signed [2:0]      dr;
  } offset_t;

  // neighbors per lattice kind
  function automatic logic [PICK_W-1:0] hood_size(input logic [LAT_W-1:0] lat);
    logic [PICK_W-1:0] s;
    case (lat)
      LAT_TRI3:    s = 4'd3;
      LAT_SQUARE4: s = 4'd4;
      LAT_HEX6:    s = 4'd6;
      LAT_TRI9:    s = 4'd9;
      LAT_TRI12:   s = 4'd12;
      default:     s = 4'd8;
    endcase
    return s;
  endfunction

  // column and row move for one pick; triangular moves mirror on odd col+row
  function automatic offset_t nbr_offset(input logic [LAT_W-1:0] lat,
                                         input logic [PICK_W-1:0] pick,
                                         input logic odd_row,
                                         input logic odd_sum);
    offset_t o;
    o.dc = 3'sd0;
    o.dr = 3'sd0;
    case (lat)
      LAT_HEX6: begin
        case (pick)
          4'd0: o.dc = 3'sd1;
          4'd1: begin o.dc = odd_row ? 3'sd0 : 3'sd1;  o.dr = -3'sd1; end
          4'd2: begin o.dc = odd_row ? -3'sd1 : 3'sd0; o.dr = -3'sd1; end
          4'd3: o.dc = -3'sd1;
          4'd4: begin o.dc = odd_row ? -3'sd1 : 3'sd0; o.dr = 3'sd1; end
          default: begin o.dc = odd_row ? 3'sd0 : 3'sd1; o.dr = 3'sd1; end
        endcase
      end
      LAT_SQUARE4: begin
        case (pick)
          4'd0: o.dc = 3'sd1;
          4'd1: o.dr = -3'sd1;
          4'd2: o.dc = -3'sd1;
          default: o.dr = 3'sd1;
        endcase
      end
      LAT_TRI3: begin
        case (pick)
          4'd0: o.dc = 3'sd1;
          4'd1: o.dr = -3'sd1;
          default: o.dr = 3'sd1;
        endcase
        if (odd_sum) begin
          o.dc = -o.dc;
          o.dr = -o.dr;
        end
      end
      LAT_TRI9: begin
        case (pick)
          4'd0: o.dc = 3'sd1;
          4'd1: begin o.dc = 3'sd1;  o.dr = -3'sd1; end
          4'd2: o.dr = -3'sd2;
          4'd3: o.dr = -3'sd1;
          4'd4: begin o.dc = -3'sd1; o.dr = -3'sd1; end
          4'd5: begin o.dc = -3'sd1; o.dr = 3'sd1; end
          4'd6: o.dr = 3'sd1;
          4'd7: o.dr = 3'sd2;
          default: begin o.dc = 3'sd1; o.dr = 3'sd1; end
        endcase
        if (odd_sum) begin
          o.dc = -o.dc;
          o.dr = -o.dr;
        end
      end
      LAT_TRI12: begin
        case (pick)
          4'd0:  o.dc = 3'sd1;
          4'd1:  begin o.dc = 3'sd1;  o.dr = -3'sd1; end
          4'd2:  begin o.dc = 3'sd1;  o.dr = -3'sd2; end
          4'd3:  o.dr = -3'sd2;
          4'd4:  o.dr = -3'sd1;
          4'd5:  begin o.dc = -3'sd1; o.dr = -3'sd1; end
          4'd6:  o.dc = -3'sd1;
          4'd7:  begin o.dc = -3'sd1; o.dr = 3'sd1; end
          4'd8:  o.dr = 3'sd1;
          4'd9:  o.dr = 3'sd2;
          4'd10: begin o.dc = 3'sd1;  o.dr = 3'sd2; end
          default: begin o.dc = 3'sd1; o.dr = 3'sd1; end
        endcase
        if (odd_sum) begin
          o.dc = -o.dc;
          o.dr = -o.dr;
        end
      end
      default: begin
        case (pick)
          4'd0: o.dc = 3'sd1;
          4'd1: begin o.dc = 3'sd1;  o.dr = -3'sd1; end
          4'd2: o.dr = -3'sd1;
          4'd3: begin o.dc = -3'sd1; o.dr = -3'sd1; end
          4'd4: o.dc = -3'sd1;
          4'd5: begin o.dc = -3'sd1; o.dr = 3'sd1; end
          4'd6: o.dr = 3'sd1;
          default: begin o.dc = 3'sd1; o.dr = 3'sd1; end
        endcase
      end
    endcase
    return o;
  endfunction

  // toroidal move by -2..2; one add or subtract suffices since size >= 2
  function automatic logic [COORD_W-1:0] wrap_move(input logic [COORD_W-1:0] v,
                                                   input logic signed [2:0] d,
                                                   input logic [CFG_W-1:0] n);
    logic signed [CFG_W+1:0] t;
    logic signed [CFG_W+1:0] sn;
    logic signed [CFG_W+1:0] r;
    sn = $signed({2'b00, n});
    t  = $signed({{(CFG_W+2-COORD_W){1'b0}}, v}) + (CFG_W+2)'(d);
    if (t < 0) begin
      r = t + sn;
    end else if (t >= sn) begin
      r = t - sn;
    end else begin
      r = t;
    end
    return r[COORD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lvm_nbr.sv =====
// neighbor position and opinion-store addresses for one input word
// depends on lvm_pkg (offset table, wrap and size functions)
`timescale 1ns / 1ps
`default_nettype none

module lvm_nbr import lvm_pkg::*; #(
  parameter int ADDR_W = 12
) (
  input  in_word_t             item,
  input  logic [LAT_W-1:0]     lattice,
  input  logic [CFG_W-1:0]     cols,
  input  logic [CFG_W-1:0]     rows,
  output nbr_res_t             res,
  output logic [ADDR_W-1:0]    cell_addr,
  output logic [ADDR_W-1:0]    nbr_addr
);

  offset_t           off;
  logic [PICK_W-1:0] size;
  logic [COORD_W-1:0] ncol;
  logic [COORD_W-1:0] nrow;
  logic [NPOS_W-1:0] cell_lin;
  logic [NPOS_W-1:0] nbr_lin;
  logic              bad;

  // lattice move for this cell and pick
  always_comb begin
    size = hood_size(lattice);
    off  = nbr_offset(lattice, item.neighbor_pick, item.cell_row[0],
                      item.cell_col[0] ^ item.cell_row[0]);
    ncol = wrap_move(item.cell_col, off.dc, cols);
    nrow = wrap_move(item.cell_row, off.dr, rows);
  end

  // range check on cell and pick
  assign bad = ({1'b0, item.cell_col} >= cols) || ({1'b0, item.cell_row} >= rows) ||
               ((item.kind == KIND_STEP) && (item.neighbor_pick >= size));

  // row-major linear addresses
  assign cell_lin  = NPOS_W'(item.cell_row) * NPOS_W'(cols) + NPOS_W'(item.cell_col);
  assign nbr_lin   = NPOS_W'(nrow) * NPOS_W'(cols) + NPOS_W'(ncol);
  assign cell_addr = ADDR_W'(cell_lin);
  assign nbr_addr  = ADDR_W'(nbr_lin);

  assign res.ncol = ncol;
  assign res.nrow = nrow;
  assign res.bad  = bad;

endmodule

`default_nettype wire

// ===== hdl/lvm_store.sv =====
// opinion memory: one write port, two registered read ports
// depends on lvm_pkg for the opinion width
`timescale 1ns / 1ps
`default_nettype none

module lvm_store import lvm_pkg::*; #(
  parameter int DEPTH  = 4096,
  parameter int ADDR_W = 12
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_W-1:0]    rd_addr_a,
  input  logic [ADDR_W-1:0]    rd_addr_b,
  output logic [OPINION_W-1:0] rd_data_a,
  output logic [OPINION_W-1:0] rd_data_b,
  input  logic                 wr_en,
  input  logic [ADDR_W-1:0]    wr_addr,
  input  logic [OPINION_W-1:0] wr_data
);

  logic [OPINION_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lvm_tally.sv =====
// per-party counts and the consensus flag
// depends on lvm_pkg for count widths and the update struct
`timescale 1ns / 1ps
`default_nettype none

module lvm_tally import lvm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  tally_op_t         op,
  input  logic [NPOS_W-1:0] npos,
  output logic              consensus
);

  logic [COUNT_W-1:0] count_r   [NUM_COUNTS];
  logic [COUNT_W-1:0] count_nxt [NUM_COUNTS];

  // count moves, wrapping at the count width
  always_comb begin
    for (int p = 0; p < NUM_COUNTS; p++) begin
      count_nxt[p] = count_r[p];
      if (op.inc_en && (op.inc_idx == OPINION_W'(p))) begin
        count_nxt[p] = count_nxt[p] + 1'b1;
      end
      if (op.dec_en && (op.dec_idx == OPINION_W'(p))) begin
        count_nxt[p] = count_nxt[p] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_COUNTS; p++) begin
        count_r[p] <= '0;
      end
    end else begin
      for (int p = 0; p < NUM_COUNTS; p++) begin
        count_r[p] <= count_nxt[p];
      end
    end
  end

  // one party holding every position, after this update
  always_comb begin
    consensus = 1'b0;
    for (int p = 0; p < NUM_COUNTS; p++) begin
      if ({1'b0, count_nxt[p]} == npos) begin
        consensus = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lattice_voter_model_step_top.sv =====
// Voter-model step on a toroidal opinion grid. At the accept edge the address
// unit sends the cell and its wrapped neighbor to the two read ports of the
// opinion memory. In the write-back state, once the output register is free
// or draining, the opinion is written back, the party counts move and the
// result word is loaded into the output register; an out-of-range word only
// loads its result. A new word is accepted once the write-back is done, so
// no word is taken before the last is through; a result waiting in the output
// register does not block the next accept, only the following write-back.
// Every cell must be loaded before it is read; there is no clearing pass.
// depends on lvm_pkg, lvm_nbr, lvm_store, lvm_tally and the macros header
`timescale 1ns / 1ps
`default_nettype none

`include "lattice_voter_model_step_top_macros.svh"

module lattice_voter_model_step_top import lvm_pkg::*; #(
  parameter int MAX_COLS    = DEF_MAX_COLS,
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int NUM_PARTIES = DEF_NUM_PARTIES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COL_CAP = (MAX_COLS > CFG_MAX) ? CFG_MAX : MAX_COLS;
  localparam int ROW_CAP = (MAX_ROWS > CFG_MAX) ? CFG_MAX : MAX_ROWS;
  localparam logic [CFG_W-1:0]     COL_CAP_V = CFG_W'(COL_CAP);
  localparam logic [CFG_W-1:0]     ROW_CAP_V = CFG_W'(ROW_CAP);
  localparam logic [OPINION_W-1:0] PARTY_LO  = OPINION_W'(3 - NUM_PARTIES);

  logic [LAT_W-1:0]     lattice_r;
  logic [CFG_W-1:0]     grid_cols_r;
  logic [CFG_W-1:0]     grid_rows_r;
  logic [CFG_W-1:0]     cols;
  logic [CFG_W-1:0]     rows;
  logic [NPOS_W-1:0]    npos;

  state_t               state_r;
  state_t               state_nxt;
  logic                 accept;
  logic                 wb_go;

  in_word_t             item_r;
  nbr_res_t             nbr_c;
  nbr_res_t             nbr_r;
  logic [ADDR_W-1:0]    cell_addr_c;
  logic [ADDR_W-1:0]    nbr_addr_c;
  logic [ADDR_W-1:0]    cell_addr_r;

  logic [OPINION_W-1:0] cell_op;
  logic [OPINION_W-1:0] nbr_op;
  logic [OPINION_W-1:0] load_op;
  logic                 mem_wr_en;
  logic [OPINION_W-1:0] mem_wr_data;
  tally_op_t            tally_op;
  logic                 consensus_c;
  out_word_t            res_c;

  out_word_t            out_data_r;
  logic                 out_valid_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lattice_r   <= LAT_SQUARE8;
      grid_cols_r <= RST_COLS;
      grid_rows_r <= RST_ROWS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NEIGHBORHOOD: lattice_r   <= cfg_wdata[LAT_W-1:0];
        REG_GRID_COLUMNS: grid_cols_r <= cfg_wdata;
        REG_GRID_ROWS:    grid_rows_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // grid size in use
  always_comb begin
    cols = grid_cols_r;
    if (grid_cols_r < MIN_SIZE) begin
      cols = MIN_SIZE;
    end else if (grid_cols_r > COL_CAP_V) begin
      cols = COL_CAP_V;
    end
    rows = grid_rows_r;
    if (grid_rows_r < MIN_SIZE) begin
      rows = MIN_SIZE;
    end else if (grid_rows_r > ROW_CAP_V) begin
      rows = ROW_CAP_V;
    end
  end

  assign npos = NPOS_W'(cols) * NPOS_W'(rows);

  lvm_nbr #(
    .ADDR_W (ADDR_W)
  ) u_nbr (
    .item      (in_data),
    .lattice   (lattice_r),
    .cols      (cols),
    .rows      (rows),
    .res       (nbr_c),
    .cell_addr (cell_addr_c),
    .nbr_addr  (nbr_addr_c)
  );

  lvm_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (cell_addr_c),
    .rd_addr_b (nbr_addr_c),
    .rd_data_a (cell_op),
    .rd_data_b (nbr_op),
    .wr_en     (mem_wr_en),
    .wr_addr   (cell_addr_r),
    .wr_data   (mem_wr_data)
  );

  lvm_tally u_tally (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (tally_op),
    .npos      (npos),
    .consensus (consensus_c)
  );

  // handshake and sequencing
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign wb_go    = (state_r == ST_WB) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // word capture at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r      <= in_data;
      nbr_r       <= nbr_c;
      cell_addr_r <= cell_addr_c;
    end
  end

  // clamped load opinion
  always_comb begin
    load_op = item_r.load_opinion;
    if (load_op > OPINION_MAX) begin
      load_op = OPINION_MAX;
    end
    if (load_op < PARTY_LO) begin
      load_op = PARTY_LO;
    end
  end

  // next state, write-back and result word
  always_comb begin
    state_nxt   = state_r;
    mem_wr_en   = 1'b0;
    mem_wr_data = load_op;
    tally_op    = '0;
    res_c       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_WB;
        end
      end
      ST_WB: begin
        if (wb_go) begin
          state_nxt = ST_IDLE;
          if (!nbr_r.bad) begin
            res_c.prev_opinion = cell_op;
            if (item_r.kind == KIND_LOAD) begin
              res_c.post_opinion = load_op;
              mem_wr_en          = 1'b1;
              mem_wr_data        = load_op;
              tally_op.inc_en    = 1'b1;
              tally_op.inc_idx   = load_op;
            end else begin
              res_c.post_opinion = nbr_op;
              res_c.neighbor_col = nbr_r.ncol;
              res_c.neighbor_row = nbr_r.nrow;
              if (nbr_op != cell_op) begin
                res_c.changed    = 1'b1;
                mem_wr_en        = 1'b1;
                mem_wr_data      = nbr_op;
                tally_op.inc_en  = 1'b1;
                tally_op.inc_idx = nbr_op;
                tally_op.dec_en  = 1'b1;
                tally_op.dec_idx = cell_op;
              end
            end
          end
          res_c.bad_coord = nbr_r.bad;
          res_c.consensus = consensus_c;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (wb_go) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_go) begin
      out_data_r <= res_c;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `LVM_ASSERT_NEXT(a_accept_to_wb, accept, state_r == ST_WB, "accept did not enter write-back")
  `LVM_ASSERT_NOW(a_write_in_wb, mem_wr_en, wb_go, "memory write outside write-back")
  `LVM_ASSERT_NOW(a_bad_no_write, (state_r == ST_WB) && nbr_r.bad, !mem_wr_en,
                  "out-of-range word wrote the memory")
  `LVM_ASSERT_NOW(a_rose_after_wb, $rose(out_valid_r), $past(state_r) == ST_WB,
                  "result appeared without a write-back")
  `LVM_ASSERT_NOW(a_changed_differs, out_valid_r && out_data_r.changed,
                  out_data_r.prev_opinion != out_data_r.post_opinion,
                  "changed flag with equal opinions")

endmodule

`default_nettype wire
